// ===== rtl/ufrx_pkg.sv =====
// ----------------------------------------------------------------------------
// ufrx_pkg - shared types and constants of the frame receiver
// Phase and status codes, register indexes, the result beat layout and the
// frame limits.
// ----------------------------------------------------------------------------
package ufrx_pkg;

	// frame limits
	localparam int BUFFER_BYTES = 64;
	localparam int HEADER_BYTES = 3;
	// wide enough for length + header and for the buffer limit
	localparam int LEN_CMP_W    = $clog2(BUFFER_BYTES + 256);

	localparam int BYTE_W       = 8;
	localparam int CFG_IDX_W    = 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TYPE = 1'd1;

	// register reset values
	localparam logic [BYTE_W-1:0] START_BYTE_RST    = 8'd126;
	localparam logic [BYTE_W-1:0] EXPECTED_TYPE_RST = 8'd49;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_SECOND  = 2'd1,
		PH_LENGTH  = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_SUM    = 3'd1,
		ST_WRONG_TYPE = 3'd2,
		ST_TOO_BIG    = 3'd3,
		ST_EMPTY      = 3'd4
	} frame_status_t;

	// one result beat
	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] byte_index;
		logic              last_of_frame;
		frame_status_t     frame_status;
	} result_t;

	// deframer state as seen by the top level
	typedef struct packed {
		phase_t            phase;
		logic [BYTE_W-1:0] bytes_left;
	} dfr_state_t;

endpackage

// ===== rtl/ufrx_if.sv =====
// ----------------------------------------------------------------------------
// ufrx_if - valid/ready channels of the frame receiver
// ufrx_rx_if carries received bytes, ufrx_res_if carries result beats.
// ----------------------------------------------------------------------------
interface ufrx_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufrx_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [7:0] byte_index;
	logic       last_of_frame;
	logic [2:0] frame_status;

	modport source (output valid, output payload_byte, output byte_index,
		output last_of_frame, output frame_status, input ready);
	modport sink   (input valid, input payload_byte, input byte_index,
		input last_of_frame, input frame_status, output ready);
endinterface

// ===== rtl/ufrx_deframer.sv =====
// ----------------------------------------------------------------------------
// ufrx_deframer - frame state machine
// Steps once per byte: start byte hunt, length check, payload pass-through
// with running checksum and type check. Result is combinational on the step.
// ----------------------------------------------------------------------------
module ufrx_deframer
	import ufrx_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [BYTE_W-1:0] start_byte,
	input  logic [BYTE_W-1:0] expected_type,
	output logic              has_result,
	output result_t           result,
	output dfr_state_t        state
);

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] bytes_left_q, bytes_left_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic [BYTE_W-1:0] pos_q, pos_d;
	logic              type_ok_q, type_ok_d;

	logic              too_big;
	logic              is_start;
	logic              last_byte;
	logic              type_ok_now;

	// shared decodes
	assign is_start    = (rx_byte == start_byte);
	assign too_big     = (LEN_CMP_W'(rx_byte) + LEN_CMP_W'(HEADER_BYTES))
		> LEN_CMP_W'(BUFFER_BYTES);
	assign last_byte   = (bytes_left_q <= 8'd1);
	// type is judged on the first payload byte, held afterwards
	assign type_ok_now = (pos_q == '0) ? (rx_byte == expected_type) : type_ok_q;

	// next state
	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		sum_d        = sum_q;
		pos_d        = pos_q;
		type_ok_d    = type_ok_q;
		if (step) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (is_start) phase_d = PH_SECOND;
				end
				PH_SECOND: begin
					phase_d = is_start ? PH_LENGTH : PH_HUNT;
				end
				PH_LENGTH: begin
					if (too_big || rx_byte == '0) begin
						phase_d = PH_HUNT;
					end else begin
						bytes_left_d = rx_byte;
						sum_d        = rx_byte;
						pos_d        = '0;
						type_ok_d    = 1'b0;
						phase_d      = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					type_ok_d = type_ok_now;
					if (last_byte) begin
						phase_d      = PH_HUNT;
						bytes_left_d = '0;
					end else begin
						sum_d        = sum_q + rx_byte;
						pos_d        = pos_q + 8'd1;
						bytes_left_d = bytes_left_q - 8'd1;
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	// outputs
	always_comb begin
		has_result           = 1'b0;
		result.payload_byte  = rx_byte;
		result.byte_index    = '0;
		result.last_of_frame = 1'b0;
		result.frame_status  = ST_OK;
		unique case (phase_q)
			PH_HUNT, PH_SECOND: has_result = 1'b0;
			PH_LENGTH: begin
				if (too_big) begin
					has_result           = step;
					result.last_of_frame = 1'b1;
					result.frame_status  = ST_TOO_BIG;
				end else if (rx_byte == '0) begin
					has_result           = step;
					result.last_of_frame = 1'b1;
					result.frame_status  = ST_EMPTY;
				end
			end
			PH_PAYLOAD: begin
				has_result        = step;
				result.byte_index = pos_q;
				if (last_byte) begin
					result.last_of_frame = 1'b1;
					// bad checksum wins over wrong type
					if (rx_byte != sum_q)  result.frame_status = ST_BAD_SUM;
					else if (!type_ok_now) result.frame_status = ST_WRONG_TYPE;
					else                   result.frame_status = ST_OK;
				end
			end
			default: has_result = 1'b0;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			bytes_left_q <= '0;
			sum_q        <= '0;
			pos_q        <= '0;
			type_ok_q    <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			sum_q        <= sum_d;
			pos_q        <= pos_d;
			type_ok_q    <= type_ok_d;
		end
	end

	assign state.phase      = phase_q;
	assign state.bytes_left = bytes_left_q;

endmodule

// ===== rtl/uart_frame_receiver_with_sum_check_core.sv =====
// ----------------------------------------------------------------------------
// uart_frame_receiver_with_sum_check_core - serial frame deframer
// Double start byte, length, payload with additive checksum; each payload
// byte goes out with its index; the last, and a bad length, carry the status.
//
//   channel | dir | beat
//   rx      | in  | rx_byte
//   frame   | out | payload_byte, byte_index, last_of_frame, frame_status
//   cfg     | in  | write only: cfg_we, cfg_index, cfg_wdata
//
// One byte per cycle sustained unless the frame channel stalls. A byte is
// registered on acceptance, stepped through the frame state machine once the
// output register is free, and the step loads its result (if any) there.
// Reset clears the state machine and loads the register defaults.
// A stalled frame channel holds the output register; rx keeps accepting as
// long as the input register can move on, so one beat of slack each side.
// ----------------------------------------------------------------------------
module uart_frame_receiver_with_sum_check_core
	import ufrx_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	ufrx_rx_if.sink              rx,
	ufrx_res_if.source           frame,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_wdata
);

	logic [BYTE_W-1:0] start_byte_q;
	logic [BYTE_W-1:0] expected_type_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] rx_byte_s1;
	logic              valid_s2;
	result_t           res_s2;

	logic              s2_free;
	logic              adv_s1;
	logic              has_result;
	result_t           result;
	dfr_state_t        dfr_state;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q    <= START_BYTE_RST;
			expected_type_q <= EXPECTED_TYPE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_BYTE:    start_byte_q    <= cfg_wdata;
				CFG_EXPECTED_TYPE: expected_type_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// flow control
	assign s2_free  = !valid_s2 || frame.ready;
	assign adv_s1   = valid_s1 && s2_free;
	assign rx.ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) rx_byte_s1 <= rx.rx_byte;
	end

	ufrx_deframer u_dfr (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv_s1),
		.rx_byte       (rx_byte_s1),
		.start_byte    (start_byte_q),
		.expected_type (expected_type_q),
		.has_result    (has_result),
		.result        (result),
		.state         (dfr_state)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= adv_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result) res_s2 <= result;
	end

	assign frame.valid         = valid_s2;
	assign frame.payload_byte  = res_s2.payload_byte;
	assign frame.byte_index    = res_s2.byte_index;
	assign frame.last_of_frame = res_s2.last_of_frame;
	assign frame.frame_status  = res_s2.frame_status;

	// checks
	a_mid_frame_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.last_of_frame |-> res_s2.frame_status == ST_OK)
		else $error("non-final beat carries a status");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		dfr_state.phase == PH_PAYLOAD |-> dfr_state.bytes_left != '0)
		else $error("payload phase with no bytes left");

	a_last_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && has_result && result.last_of_frame |=> dfr_state.phase == PH_HUNT)
		else $error("frame end did not return to hunting");

	a_s1_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(rx_byte_s1))
		else $error("held input beat lost");

endmodule

// ===== tb/tb_uart_frame_receiver_with_sum_check_core.sv =====
// ----------------------------------------------------------------------------
// tb_uart_frame_receiver_with_sum_check_core - self-checking bench of the deframer
// Feeds received bytes through the rx channel and checks every frame beat
// against an in-bench deframer that tracks the same phase, count and sum.
// Runs a directed set of frames, then random traffic (mostly well-formed
// frames, some noise and broken starts) under several register settings,
// with random idle bursts on both channels except in the last setting.
// ----------------------------------------------------------------------------
module tb_uart_frame_receiver_with_sum_check_core
	import ufrx_pkg::*;
();

	localparam int PIPE_CYCLES = 8;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_BYTES = 75;
	localparam int MAX_LEN     = BUFFER_BYTES - HEADER_BYTES;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_wdata;

	ufrx_rx_if  rx_if ();
	ufrx_res_if frame_if ();

	uart_frame_receiver_with_sum_check_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.frame     (frame_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// register copies
	logic [7:0] start_val;
	logic [7:0] type_val;

	// deframer state
	phase_t     dfr_phase;
	logic [7:0] left_cnt;
	logic [7:0] sum_acc;
	logic [7:0] pos_cnt;
	logic       type_ok;

	logic [7:0] rx_bytes_q[$];
	result_t    expected_beats[$];

	int  bytes_queued;
	int  bytes_taken;
	int  beats_out;
	int  frames_ended;
	int  errors;
	int  send_gap;
	int  hold_gap;
	int  quiet_cycles;
	bit  calm;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// one line per mismatch, printing capped
	task automatic report_mismatch(input string what, input int got, input int want);
		if (errors < 40)
			$display("MISMATCH beat %0d %s: got %0d, wanted %0d", beats_out, what, got, want);
		errors++;
	endtask

	// step the deframer by one received byte, queue any beat it yields
	function automatic void deframe_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		case (dfr_phase)
		PH_HUNT: begin
			if (b == start_val)
				dfr_phase = PH_SECOND;
		end
		PH_SECOND: begin
			dfr_phase = (b == start_val) ? PH_LENGTH : PH_HUNT;
		end
		PH_LENGTH: begin
			if (int'(b) + HEADER_BYTES > BUFFER_BYTES) begin
				dfr_phase = PH_HUNT;
				r.payload_byte = b;
				r.last_of_frame = 1'b1;
				r.frame_status = ST_TOO_BIG;
				expected_beats.push_back(r);
			end else if (b == 8'd0) begin
				dfr_phase = PH_HUNT;
				r.last_of_frame = 1'b1;
				r.frame_status = ST_EMPTY;
				expected_beats.push_back(r);
			end else begin
				left_cnt = b;
				sum_acc = b;
				pos_cnt = 8'd0;
				type_ok = 1'b0;
				dfr_phase = PH_PAYLOAD;
			end
		end
		default: begin
			r.payload_byte = b;
			r.byte_index = pos_cnt;
			if (pos_cnt == 8'd0)
				type_ok = (b == type_val);
			if (left_cnt <= 8'd1) begin
				// checksum byte: bad sum outranks wrong type
				r.last_of_frame = 1'b1;
				if (b != sum_acc)
					r.frame_status = ST_BAD_SUM;
				else if (!type_ok)
					r.frame_status = ST_WRONG_TYPE;
				else
					r.frame_status = ST_OK;
				dfr_phase = PH_HUNT;
				left_cnt = 8'd0;
			end else begin
				sum_acc = sum_acc + b;
				pos_cnt = pos_cnt + 8'd1;
				left_cnt = left_cnt - 8'd1;
			end
			expected_beats.push_back(r);
		end
		endcase
	endfunction

	// rx driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
			rx_if.rx_byte <= '0;
			send_gap = 0;
			dfr_phase = PH_HUNT;
			left_cnt = '0;
			sum_acc = '0;
			pos_cnt = '0;
			type_ok = 1'b0;
		end else begin
			if (rx_if.valid && rx_if.ready) begin
				deframe_byte(rx_if.rx_byte);
				bytes_taken++;
			end
			if (rx_if.valid && !rx_if.ready) begin
				// beat still waiting, hold it
			end else if (send_gap > 0) begin
				send_gap--;
				rx_if.valid <= 1'b0;
			end else if (rx_bytes_q.size() != 0) begin
				rx_if.valid <= 1'b1;
				rx_if.rx_byte <= rx_bytes_q.pop_front();
				if (!calm && $urandom_range(0, 7) == 0)
					send_gap = $urandom_range(1, 15);
			end else begin
				rx_if.valid <= 1'b0;
			end
		end
	end

	// frame monitor and checker
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			frame_if.ready <= 1'b0;
			hold_gap = 0;
		end else begin
			if (frame_if.valid && frame_if.ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("beat with nothing pending, payload_byte",
						frame_if.payload_byte, -1);
				end else begin
					want = expected_beats.pop_front();
					if (frame_if.payload_byte !== want.payload_byte)
						report_mismatch("payload_byte", frame_if.payload_byte,
							want.payload_byte);
					if (frame_if.byte_index !== want.byte_index)
						report_mismatch("byte_index", frame_if.byte_index, want.byte_index);
					if (frame_if.last_of_frame !== want.last_of_frame)
						report_mismatch("last_of_frame", frame_if.last_of_frame,
							want.last_of_frame);
					if (frame_if.frame_status !== want.frame_status)
						report_mismatch("frame_status", frame_if.frame_status,
							int'(want.frame_status));
				end
				if (frame_if.last_of_frame === 1'b1)
					frames_ended++;
				beats_out++;
			end
			if (hold_gap > 0) begin
				hold_gap--;
				frame_if.ready <= 1'b0;
			end else begin
				frame_if.ready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					hold_gap = $urandom_range(1, 15);
			end
		end
	end

	// watchdog: cycles with no beat on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout after %0d quiet cycles", quiet_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		rx_bytes_q.push_back(b);
		bytes_queued++;
	endtask

	// wait until every byte is taken and every beat has come out
	task automatic wait_idle();
		do
			@(posedge clk);
		while (bytes_taken != bytes_queued || expected_beats.size() != 0);
		repeat (PIPE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_START_BYTE)
			start_val = val;
		else if (idx == CFG_EXPECTED_TYPE)
			type_val = val;
	endtask

	// double start, length, payload; last payload byte is the checksum
	task automatic queue_frame(input logic [7:0] len, input bit type_right,
		input bit sum_right);
		logic [7:0] sum;
		logic [7:0] b;
		send_byte(start_val);
		send_byte(start_val);
		send_byte(len);
		sum = len;
		if (int'(len) <= MAX_LEN) begin
			for (int i = 0; i < int'(len); i++) begin
				if (i == int'(len) - 1) begin
					b = sum_right ? sum : 8'($urandom);
					if (!sum_right && b == sum)
						b = b ^ 8'h01;
				end else if (i == 0) begin
					b = type_right ? type_val : 8'($urandom);
				end else begin
					b = 8'($urandom);
				end
				sum = sum + b;
				send_byte(b);
			end
		end
	endtask

	task automatic queue_random_traffic(input int n_bytes);
		int         base;
		int         kind;
		int         len;
		logic [7:0] b;
		base = bytes_queued;
		while (bytes_queued - base < n_bytes) begin
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, MAX_LEN)
					: $urandom_range(1, 8);
				queue_frame(8'(len), $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
			end else if (kind == 14) begin
				queue_frame(8'd0, 1'b1, 1'b1);
			end else if (kind == 15) begin
				queue_frame(8'($urandom_range(MAX_LEN + 1, 255)), 1'b1, 1'b1);
			end else if (kind < 18) begin
				// lone start byte followed by something else
				b = 8'($urandom);
				if (b == start_val)
					b = b ^ 8'h80;
				send_byte(start_val);
				send_byte(b);
			end else begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end
		end
	endtask

	// stimulus and end of run
	initial begin
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		start_val = START_BYTE_RST;
		type_val = EXPECTED_TYPE_RST;
		calm = 1'b0;
		arst_n = 1'b0;

		// directed frames under the reset settings
		// good two-byte frame
		send_byte(start_val); send_byte(start_val); send_byte(8'h02);
		send_byte(8'h31); send_byte(8'h33);
		// second start missing
		send_byte(start_val); send_byte(8'h05);
		// empty frame
		send_byte(start_val); send_byte(start_val); send_byte(8'h00);
		// too big: largest length, then just over the limit
		send_byte(start_val); send_byte(start_val); send_byte(8'hFF);
		send_byte(start_val); send_byte(start_val); send_byte(8'(MAX_LEN + 1));
		// one-byte payload checked against the length alone, wrong type
		send_byte(start_val); send_byte(start_val); send_byte(8'h01); send_byte(8'h01);
		// bad sum and wrong type together
		send_byte(start_val); send_byte(start_val); send_byte(8'h02);
		send_byte(8'h00); send_byte(8'h05);
		queue_random_traffic(60);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// both registers at zero, longest legal frame included
		write_reg(CFG_START_BYTE, 8'h00);
		write_reg(CFG_EXPECTED_TYPE, 8'h00);
		queue_frame(8'(MAX_LEN), 1'b1, 1'b1);
		queue_random_traffic(PHASE_BYTES);
		wait_idle();

		write_reg(CFG_START_BYTE, 8'hFF);
		write_reg(CFG_EXPECTED_TYPE, 8'hFF);
		queue_random_traffic(PHASE_BYTES);
		wait_idle();

		write_reg(CFG_START_BYTE, 8'($urandom));
		write_reg(CFG_EXPECTED_TYPE, 8'($urandom));
		queue_random_traffic(PHASE_BYTES);
		wait_idle();

		// back to defaults, both sides flat out
		write_reg(CFG_START_BYTE, START_BYTE_RST);
		write_reg(CFG_EXPECTED_TYPE, EXPECTED_TYPE_RST);
		calm = 1'b1;
		queue_random_traffic(PHASE_BYTES);
		wait_idle();

		if (expected_beats.size() != 0)
			report_mismatch("beats never delivered", 0, expected_beats.size());
		$display("Sent %0d bytes under 5 register settings; checked %0d beats, %0d frame ends",
			bytes_taken, beats_out, frames_ended);
		$display("Mismatches: %0d", errors);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
